[rtl/envc_pkg.sv]
// ----------------------------------------------------------------------------
// envc_pkg : shared types and constants for the envelope compressor
// Widths, fixed-point constants, configuration and result records, and the
// reciprocal table used for the Taylor-series divides.
// ----------------------------------------------------------------------------
package envc_pkg;

  localparam int GAIN_TABLE_BITS = 10;   // gain index resolution

  localparam int SAMPLE_W   = 24;        // Q1.23 sample / Q0.23 level
  localparam int COEF_W     = 16;        // Q0.16 coefficients
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int MUL_W      = 32;        // shared multiplier operand width
  localparam int PROD_W     = 2 * MUL_W;
  localparam int X_FRAC     = 39;        // (env - thr) * slope is Q0.39
  localparam int Y_W        = 29;        // exponent argument, Q0.32, < 2^29
  localparam int ACC_W      = 33;        // series sum, Q1.32
  localparam int GAIN_W     = 17;        // Q1.16 gain
  localparam int PM_W       = SAMPLE_W + GAIN_W;  // |sample| * gain
  localparam int Q_W        = PM_W + 1 - 16;      // rounded magnitude
  localparam int K_W        = 4;

  localparam logic [Y_W-1:0]      LN10_OVER_20 = 29'd494476384;  // ln(10)/20, Q0.32
  localparam logic [ACC_W-1:0]    ACC_ONE      = 33'h1_0000_0000;
  localparam logic [ACC_W:0]      ROUND_HALF   = 34'd32768;
  localparam logic [GAIN_W-1:0]   GAIN_ONE     = 17'h1_0000;
  localparam logic [SAMPLE_W-1:0] ENV_MAX      = 24'h80_0000;
  localparam logic [K_W-1:0]      K_FIRST      = 4'd2;
  localparam logic [K_W-1:0]      K_LAST       = 4'd8;

  typedef struct packed {
    logic [SAMPLE_W-1:0] threshold;
    logic [COEF_W-1:0]   ratio_slope;
    logic [COEF_W-1:0]   attack_coefficient;
    logic [COEF_W-1:0]   release_coefficient;
  } envc_cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       reducing;
  } envc_res_t;

  // ceil(2^32 / k): floor(t * m >> 32) == floor(t / k) for t < 2^29
  function automatic logic [MUL_W-1:0] recip_k(input logic [K_W-1:0] k);
    logic [MUL_W-1:0] m;
    case (k)
      4'd2:    m = 32'h8000_0000;
      4'd3:    m = 32'd1431655766;
      4'd4:    m = 32'h4000_0000;
      4'd5:    m = 32'd858993460;
      4'd6:    m = 32'd715827883;
      4'd7:    m = 32'd613566757;
      4'd8:    m = 32'h2000_0000;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

[rtl/envc_if.sv]
// ----------------------------------------------------------------------------
// envc_if : item channels of the envelope compressor
// Valid/ready channels for input samples and compressed results.
// ----------------------------------------------------------------------------
interface envc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [envc_pkg::SAMPLE_W-1:0] sample_in;
  logic                                 block_start;

  modport source (output valid, output sample_in, output block_start, input ready);
  modport sink   (input valid, input sample_in, input block_start, output ready);
endinterface

interface envc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [envc_pkg::SAMPLE_W-1:0] sample_out;
  logic                                 reducing;

  modport source (output valid, output sample_out, output reducing, input ready);
  modport sink   (input valid, input sample_out, input reducing, output ready);
endinterface

[rtl/envc_mul.sv]
// ----------------------------------------------------------------------------
// envc_mul : shared unsigned multiplier
// 32 x 32 product, registered; the result follows in the cycle after the operands.
// ----------------------------------------------------------------------------
module envc_mul (
  input  logic                          clk,
  input  logic [envc_pkg::MUL_W-1:0]    a,
  input  logic [envc_pkg::MUL_W-1:0]    b,
  output logic [envc_pkg::PROD_W-1:0]   p_r
);

  logic [envc_pkg::PROD_W-1:0] p_nxt;

  assign p_nxt = envc_pkg::PROD_W'(a) * envc_pkg::PROD_W'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

[rtl/envc_core.sv]
// ----------------------------------------------------------------------------
// envc_core : sequencer and datapath
// Envelope update, gain index, e^-y series and output scaling, all through
// one shared multiplier stepped by a small state machine.
// ----------------------------------------------------------------------------
module envc_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_take,
  input  logic signed [envc_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 in_start,
  input  envc_pkg::envc_cfg_t                  cfg,
  output logic                                 idle,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output envc_pkg::envc_res_t                  res
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_EMUL, S_EUPD, S_THR, S_XMUL, S_YMUL, S_TERM1,
    S_DMUL, S_ACC, S_GAIN, S_OMUL, S_RND, S_OUT
  } state_t;

  state_t                            state_r, state_nxt;
  logic [envc_pkg::SAMPLE_W-1:0]     env_r, env_nxt;
  logic [envc_pkg::SAMPLE_W-1:0]     s_r, s_nxt;
  logic [envc_pkg::SAMPLE_W-1:0]     mag_r, mag_nxt;
  logic                              rise_r, rise_nxt;
  logic [envc_pkg::SAMPLE_W-1:0]     diff_r, diff_nxt;
  logic                              red_r, red_nxt;
  logic [envc_pkg::SAMPLE_W-1:0]     over_r, over_nxt;
  logic [envc_pkg::Y_W-1:0]          y_r, y_nxt;
  logic [envc_pkg::ACC_W-1:0]        acc_r, acc_nxt;
  logic [envc_pkg::K_W-1:0]          k_r, k_nxt;
  logic [envc_pkg::GAIN_W-1:0]       gain_r, gain_nxt;
  logic [envc_pkg::Q_W-1:0]          q_r, q_nxt;

  logic [envc_pkg::MUL_W-1:0]        mul_a, mul_b;
  logic [envc_pkg::PROD_W-1:0]       p_r;
  logic [envc_pkg::SAMPLE_W-1:0]     in_u;
  logic [envc_pkg::SAMPLE_W-1:0]     p_env;
  logic [envc_pkg::Y_W-1:0]          p_y;
  logic [envc_pkg::MUL_W-1:0]        p_hi;
  logic [envc_pkg::ACC_W:0]          gsum;
  logic [envc_pkg::PM_W:0]           rsum;
  logic [envc_pkg::SAMPLE_W-1:0]     sat_val;

  envc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (p_r)
  );

  assign in_u  = envc_pkg::SAMPLE_W'(in_sample);
  assign p_env = p_r[envc_pkg::COEF_W +: envc_pkg::SAMPLE_W];
  assign p_y   = p_r[envc_pkg::GAIN_TABLE_BITS +: envc_pkg::Y_W];
  assign p_hi  = p_r[envc_pkg::PROD_W-1 -: envc_pkg::MUL_W];
  assign gsum  = {1'b0, acc_r} + envc_pkg::ROUND_HALF;
  // negative samples round the magnitude up so the signed result floors
  assign rsum  = {1'b0, p_r[envc_pkg::PM_W-1:0]}
               + (s_r[envc_pkg::SAMPLE_W-1] ? (envc_pkg::PM_W+1)'(16'hFFFF)
                                            : (envc_pkg::PM_W+1)'(0));

  always_comb begin
    state_nxt = state_r;
    env_nxt   = env_r;
    s_nxt     = s_r;
    mag_nxt   = mag_r;
    rise_nxt  = rise_r;
    diff_nxt  = diff_r;
    red_nxt   = red_r;
    over_nxt  = over_r;
    y_nxt     = y_r;
    acc_nxt   = acc_r;
    k_nxt     = k_r;
    gain_nxt  = gain_r;
    q_nxt     = q_r;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          s_nxt     = in_u;
          mag_nxt   = in_u[envc_pkg::SAMPLE_W-1] ? (~in_u + 1'b1) : in_u;
          if (in_start) env_nxt = '0;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        rise_nxt  = mag_r > env_r;
        diff_nxt  = (mag_r > env_r) ? (mag_r - env_r) : (env_r - mag_r);
        state_nxt = S_EMUL;
      end
      S_EMUL: begin
        mul_a     = envc_pkg::MUL_W'(diff_r);
        mul_b     = envc_pkg::MUL_W'(rise_r ? cfg.attack_coefficient
                                            : cfg.release_coefficient);
        state_nxt = S_EUPD;
      end
      S_EUPD: begin
        env_nxt   = rise_r ? (mag_r - p_env) : (mag_r + p_env);
        state_nxt = S_THR;
      end
      S_THR: begin
        red_nxt   = env_r > cfg.threshold;
        over_nxt  = env_r - cfg.threshold;
        state_nxt = (env_r > cfg.threshold) ? S_XMUL : S_OUT;
      end
      S_XMUL: begin
        mul_a     = envc_pkg::MUL_W'(over_r);
        mul_b     = envc_pkg::MUL_W'(cfg.ratio_slope);
        state_nxt = S_YMUL;
      end
      S_YMUL: begin
        mul_a     = envc_pkg::MUL_W'(p_r[envc_pkg::X_FRAC-1 -: envc_pkg::GAIN_TABLE_BITS]);
        mul_b     = envc_pkg::MUL_W'(envc_pkg::LN10_OVER_20);
        state_nxt = S_TERM1;
      end
      S_TERM1: begin
        // first series term is y itself
        y_nxt     = p_y;
        acc_nxt   = envc_pkg::ACC_ONE - envc_pkg::ACC_W'(p_y);
        k_nxt     = envc_pkg::K_FIRST;
        mul_a     = envc_pkg::MUL_W'(p_y);
        mul_b     = envc_pkg::MUL_W'(p_y);
        state_nxt = S_DMUL;
      end
      S_DMUL: begin
        mul_a     = p_hi;
        mul_b     = envc_pkg::recip_k(k_r);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt = k_r[0] ? (acc_r - envc_pkg::ACC_W'(p_hi))
                         : (acc_r + envc_pkg::ACC_W'(p_hi));
        if (k_r == envc_pkg::K_LAST) begin
          state_nxt = S_GAIN;
        end else begin
          k_nxt     = k_r + 1'b1;
          mul_a     = p_hi;
          mul_b     = envc_pkg::MUL_W'(y_r);
          state_nxt = S_DMUL;
        end
      end
      S_GAIN: begin
        gain_nxt  = gsum[16 +: envc_pkg::GAIN_W];
        state_nxt = S_OMUL;
      end
      S_OMUL: begin
        mul_a     = envc_pkg::MUL_W'(mag_r);
        mul_b     = envc_pkg::MUL_W'(gain_r);
        state_nxt = S_RND;
      end
      S_RND: begin
        q_nxt     = rsum[envc_pkg::PM_W -: envc_pkg::Q_W];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      env_r   <= '0;
    end else begin
      state_r <= state_nxt;
      env_r   <= env_nxt;
      s_r     <= s_nxt;
      mag_r   <= mag_nxt;
      rise_r  <= rise_nxt;
      diff_r  <= diff_nxt;
      red_r   <= red_nxt;
      over_r  <= over_nxt;
      y_r     <= y_nxt;
      acc_r   <= acc_nxt;
      k_r     <= k_nxt;
      gain_r  <= gain_nxt;
      q_r     <= q_nxt;
    end
  end

  // saturate the scaled magnitude and restore the sign
  always_comb begin
    if (s_r[envc_pkg::SAMPLE_W-1]) begin
      sat_val = (q_r > envc_pkg::Q_W'(envc_pkg::ENV_MAX)) ? envc_pkg::ENV_MAX
              : (~q_r[envc_pkg::SAMPLE_W-1:0] + 1'b1);
    end else begin
      sat_val = (q_r >= envc_pkg::Q_W'(envc_pkg::ENV_MAX)) ? (envc_pkg::ENV_MAX - 1'b1)
              : q_r[envc_pkg::SAMPLE_W-1:0];
    end
  end

  assign idle           = (state_r == S_IDLE);
  assign res_valid      = (state_r == S_OUT);
  assign res.sample_out = red_r ? sat_val : s_r;
  assign res.reducing   = red_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !res_ready) |=> (state_r == S_OUT))
    else $error("result dropped while output slot busy");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DMUL || state_r == S_ACC) |->
      (k_r >= envc_pkg::K_FIRST && k_r <= envc_pkg::K_LAST))
    else $error("series term counter out of range");

  a_env_max: assert property (@(posedge clk) disable iff (!rst_n)
    env_r <= envc_pkg::ENV_MAX)
    else $error("envelope above full scale");

  a_gain_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OMUL) |-> (gain_r <= envc_pkg::GAIN_ONE))
    else $error("gain above unity");

endmodule

[rtl/envelope_compressor.sv]
// ----------------------------------------------------------------------------
// envelope_compressor : feed-forward peak-envelope compressor
// Configuration registers, output register and the compression core.
// ----------------------------------------------------------------------------
// One signed Q1.23 sample per item, one result item per sample. The block
// takes a new item only when its core is idle, so it cannot take a new item
// before it is through with the last one. Its pace is set by the single 32x32
// multiplier: the gain 10^(-x/20) is worked out per item as a Taylor series
// of e^-y, two multiplier passes per term (product, then divide by k as a
// reciprocal multiply) for seven terms; an item that leaves the envelope at or
// below the threshold skips the series. A finished result waits in the output
// register while the next item is already being worked on. Registers are
// written on cfg_we; indexes beyond the list are ignored.
// ----------------------------------------------------------------------------
module envelope_compressor (
  input  logic                              clk,
  input  logic                              rst_n,
  envc_in_if.sink                           in_if,
  envc_out_if.source                        out_if,
  input  logic                              cfg_we,
  input  logic [envc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [envc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // register map
  localparam logic [envc_pkg::CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [envc_pkg::CFG_IDX_W-1:0] REG_SLOPE     = 3'd1;
  localparam logic [envc_pkg::CFG_IDX_W-1:0] REG_ATTACK    = 3'd2;
  localparam logic [envc_pkg::CFG_IDX_W-1:0] REG_RELEASE   = 3'd3;

  envc_pkg::envc_cfg_t cfg_r, cfg_nxt;
  logic                out_valid_r, out_valid_nxt;
  envc_pkg::envc_res_t out_res_r, out_res_nxt;

  logic                core_idle;
  logic                res_valid;
  logic                slot_free;
  logic                in_take;
  envc_pkg::envc_res_t res;

  // output slot is free if empty or being drained this cycle
  assign slot_free   = !out_valid_r || out_if.ready;
  assign in_if.ready = core_idle;
  assign in_take     = in_if.valid && core_idle;

  envc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (in_take),
    .in_sample (in_if.sample_in),
    .in_start  (in_if.block_start),
    .cfg       (cfg_r),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_ready (slot_free),
    .res       (res)
  );

  // configuration write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: cfg_nxt.threshold           = cfg_wdata;
        REG_SLOPE:     cfg_nxt.ratio_slope         = cfg_wdata[envc_pkg::COEF_W-1:0];
        REG_ATTACK:    cfg_nxt.attack_coefficient  = cfg_wdata[envc_pkg::COEF_W-1:0];
        REG_RELEASE:   cfg_nxt.release_coefficient = cfg_wdata[envc_pkg::COEF_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  // output register: load a finished result, clear once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && slot_free) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold           <= 24'd4194304;
      cfg_r.ratio_slope         <= 16'd32768;
      cfg_r.attack_coefficient  <= 16'd65387;
      cfg_r.release_coefficient <= 16'd65521;
      out_valid_r               <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
      out_res_r   <= out_res_nxt;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.sample_out = out_res_r.sample_out;
  assign out_if.reducing   = out_res_r.reducing;

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench : self-checking bench for the envelope compressor
// A queue-fed driver offers samples with random gaps. A monitor with random
// back-pressure checks every result against an in-bench model of the
// envelope follower, gain lookup and output scaling. The run steps through
// several register settings, extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  // register map
  localparam logic [envc_pkg::CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd0;
  localparam logic [envc_pkg::CFG_IDX_W-1:0] REG_RATIO_SLOPE = 3'd1;
  localparam logic [envc_pkg::CFG_IDX_W-1:0] REG_ATTACK      = 3'd2;
  localparam logic [envc_pkg::CFG_IDX_W-1:0] REG_RELEASE     = 3'd3;
  localparam logic [envc_pkg::CFG_IDX_W-1:0] REG_COUNT       = 3'd4;  // first unused index

  localparam int     LUT_SIZE     = 1 << envc_pkg::GAIN_TABLE_BITS;
  localparam longint SAT_HI       = (longint'(1) << (envc_pkg::SAMPLE_W - 1)) - 1;
  localparam longint SAT_LO       = -(longint'(1) << (envc_pkg::SAMPLE_W - 1));
  localparam int     LONG_STALL   = 400;  // receiver hold-off, cycles
  localparam int     DRAIN_CYCLES = 64;   // settle time after the last result
  localparam int     RAND_PHASES  = 7;
  localparam int     PHASE_ITEMS  = 200;

  // content of a random block of samples
  typedef enum int {STYLE_LOUD, STYLE_QUIET, STYLE_EXTREME, STYLE_BURST} seq_style_t;

  typedef struct packed {
    logic signed [envc_pkg::SAMPLE_W-1:0] sample;
    logic                                 block_start;
  } sample_item_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [envc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [envc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  envc_in_if  in_ch ();
  envc_out_if out_ch ();

  envelope_compressor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch.sink),
    .out_if    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // model copy of the registers and the envelope, reset values
  logic [envc_pkg::SAMPLE_W-1:0] thr_model     = 24'd4194304;
  logic [envc_pkg::COEF_W-1:0]   slope_model   = 16'd32768;
  logic [envc_pkg::COEF_W-1:0]   attack_model  = 16'd65387;
  logic [envc_pkg::COEF_W-1:0]   release_model = 16'd65521;
  logic [envc_pkg::SAMPLE_W-1:0] env_model     = '0;

  int gain_lut [LUT_SIZE];        // Q1.16 gain per index

  sample_item_t         sample_q [$];     // samples waiting for the driver
  envc_pkg::envc_res_t  compressed_q [$]; // predicted results, oldest first

  int failures       = 0;
  int src_idle_pct   = 37;
  int sink_idle_pct  = 37;
  int stall_requests = 0;         // bumped by the sequencer
  int stall_served   = 0;         // owned by the monitor
  int stall_left     = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop, well beyond the slowest legal run.
  initial begin
    #8ms;
    $display("envelope_compressor: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------

  // e^-y by an eighth-order Taylor series in Q0.32, rounded to Q1.16.
  function automatic int gain_value(input int i);
    longint unsigned y, term, acc;
    y    = (longint'(i) * longint'(envc_pkg::LN10_OVER_20)) >> envc_pkg::GAIN_TABLE_BITS;
    term = longint'(1) << 32;
    acc  = term;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * y) >> 32) / k;
      if (k % 2) acc = acc - term;
      else       acc = acc + term;
    end
    return int'((acc + 32768) >> 16);
  endfunction

  // One sample through the envelope follower and gain stage; updates env_model.
  function automatic envc_pkg::envc_res_t compress_sample(
    input logic signed [envc_pkg::SAMPLE_W-1:0] s,
    input logic                                 start
  );
    longint              lvl, e, x, prod, q;
    int                  idx;
    envc_pkg::envc_res_t r;
    lvl = (s < 0) ? -longint'(s) : longint'(s);
    if (start) env_model = '0;
    e = longint'(env_model);
    // attack pulls towards a rising level, release otherwise
    if (lvl > e) e = lvl - (((lvl - e) * longint'(attack_model)) >>> 16);
    else         e = lvl + (((e - lvl) * longint'(release_model)) >>> 16);
    env_model = e[envc_pkg::SAMPLE_W-1:0];
    r.sample_out = s;
    r.reducing   = 1'b0;
    if (env_model > thr_model) begin
      x    = longint'(env_model - thr_model) * longint'(slope_model);
      idx  = int'((x >>> (envc_pkg::X_FRAC - envc_pkg::GAIN_TABLE_BITS)) & (LUT_SIZE - 1));
      prod = longint'(s) * longint'(gain_lut[idx]);
      q    = prod >>> 16;  // floor, negative values too
      if (q > SAT_HI) q = SAT_HI;
      if (q < SAT_LO) q = SAT_LO;
      r.sample_out = q[envc_pkg::SAMPLE_W-1:0];
      r.reducing   = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued samples, predicts at acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        compressed_q.push_back(compress_sample(in_ch.sample_in, in_ch.block_start));
      // the slot is free once the current item has gone (or there was none)
      if (!in_ch.valid || in_ch.ready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_ch.valid       <= 1'b1;
          in_ch.sample_in   <= sample_q[0].sample;
          in_ch.block_start <= sample_q[0].block_start;
          void'(sample_q.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure plus long hold-offs on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    envc_pkg::envc_res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (compressed_q.size() == 0) begin
          failures++;
          $display("%0t ERR result with nothing predicted: sample_out=%0d reducing=%0b",
                   $realtime, out_ch.sample_out, out_ch.reducing);
        end else begin
          want = compressed_q.pop_front();
          if (out_ch.sample_out !== want.sample_out) begin
            failures++;
            $display("%0t ERR sample_out expected %0d got %0d",
                     $realtime, want.sample_out, out_ch.sample_out);
          end
          if (out_ch.reducing !== want.reducing) begin
            failures++;
            $display("%0t ERR reducing expected %0b got %0b",
                     $realtime, want.reducing, out_ch.reducing);
          end
        end
      end
      if (stall_served != stall_requests) begin
        stall_served++;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic signed [envc_pkg::SAMPLE_W-1:0] s,
                           input logic start);
    sample_item_t it;
    it.sample      = s;
    it.block_start = start;
    sample_q.push_back(it);
  endtask

  // Only ever called with the block idle, so the model can follow at once.
  task automatic write_reg(input logic [envc_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [envc_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_THRESHOLD:   thr_model     = val;
      REG_RATIO_SLOPE: slope_model   = val[envc_pkg::COEF_W-1:0];
      REG_ATTACK:      attack_model  = val[envc_pkg::COEF_W-1:0];
      REG_RELEASE:     release_model = val[envc_pkg::COEF_W-1:0];
      default: ;  // beyond the map, dropped by the block
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender pauses here until every predicted result has come back.
  task automatic drain();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_ch.valid || compressed_q.size() != 0);
  endtask

  function automatic logic signed [envc_pkg::SAMPLE_W-1:0] pick_sample(
    input seq_style_t style
  );
    logic signed [envc_pkg::SAMPLE_W-1:0] v;
    case (style)
      STYLE_QUIET: v = envc_pkg::SAMPLE_W'($urandom_range(131071)) - 24'sd65536;
      STYLE_EXTREME: begin
        case ($urandom_range(4))
          0:       v = 24'h7F_FFFF;
          1:       v = 24'h80_0000;
          2:       v = 24'h00_0000;
          3:       v = 24'hFF_FFFF;
          default: v = 24'h00_0001;
        endcase
      end
      default: v = envc_pkg::SAMPLE_W'($urandom());
    endcase
    return v;
  endfunction

  // Mostly whole buffers (start flag on the first sample), some loose noise.
  task automatic queue_random(input int n);
    int         made, len;
    seq_style_t style;
    made = 0;
    while (made < n) begin
      if ($urandom_range(99) < 85) begin
        len   = $urandom_range(40, 4);
        style = seq_style_t'($urandom_range(3));
        for (int j = 0; j < len; j++) begin
          if (style == STYLE_BURST)
            push_item(pick_sample(j < len / 2 ? STYLE_LOUD : STYLE_QUIET), j == 0);
          else
            push_item(pick_sample(style), j == 0);
        end
      end else begin
        len = $urandom_range(8, 1);
        for (int j = 0; j < len; j++)
          push_item(envc_pkg::SAMPLE_W'($urandom()), $urandom_range(9) == 0);
      end
      made += len;
    end
  endtask

  function automatic logic [envc_pkg::CFG_DATA_W-1:0] pick_coef();
    case ($urandom_range(3))
      0:       return '0;
      1:       return 24'(16'hFFFF);
      2:       return 24'($urandom_range(65535, 60000));
      default: return 24'($urandom_range(65535));
    endcase
  endfunction

  task automatic randomise_config();
    logic [envc_pkg::CFG_DATA_W-1:0] thr, slope;
    case ($urandom_range(5))
      0:       thr = '0;
      1:       thr = envc_pkg::ENV_MAX;
      2:       thr = 24'hFF_FFFF;
      3:       thr = 24'($urandom_range(1 << 20));
      4:       thr = 24'($urandom_range(envc_pkg::ENV_MAX));
      default: thr = 24'($urandom());
    endcase
    case ($urandom_range(2))
      0:       slope = '0;
      1:       slope = 24'(16'hFFFF);
      default: slope = 24'($urandom_range(65535));
    endcase
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_RATIO_SLOPE, slope);
    write_reg(REG_ATTACK, pick_coef());
    write_reg(REG_RELEASE, pick_coef());
    if ($urandom_range(1))
      write_reg(REG_COUNT + envc_pkg::CFG_IDX_W'($urandom_range(3)), 24'($urandom()));
    close_writes();
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.sample_in   = '0;
    in_ch.block_start = 1'b0;
    out_ch.ready      = 1'b0;
    for (int i = 0; i < LUT_SIZE; i++)
      gain_lut[i] = gain_value(i);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: slow attack keeps the envelope under threshold
    push_item(24'sd0, 1'b1);
    push_item(24'h7F_FFFF, 1'b0);
    push_item(24'h80_0000, 1'b0);
    push_item(24'hFF_FFFF, 1'b0);
    push_item(24'sd1, 1'b1);
    push_item(24'h80_0000, 1'b1);
    push_item(24'h7F_FFFF, 1'b0);
    push_item(24'h55_AAAA, 1'b0);
    drain();

    // zero coefficients: envelope jumps to the level; zero threshold and
    // full slope reach the top of the gain table
    write_reg(REG_THRESHOLD, '0);
    write_reg(REG_RATIO_SLOPE, 24'(16'hFFFF));
    write_reg(REG_ATTACK, '0);
    write_reg(REG_RELEASE, '0);
    close_writes();
    push_item(24'h80_0000, 1'b1);
    push_item(24'h7F_FFFF, 1'b0);
    push_item(24'sd0, 1'b0);
    push_item(24'sd1, 1'b0);
    push_item(24'hFF_FFFF, 1'b0);
    push_item(24'sd4194304, 1'b0);
    push_item(-24'sd4194305, 1'b0);
    drain();

    // zero slope: reducing flagged with unity gain; envelope equal to the
    // threshold must not reduce
    write_reg(REG_THRESHOLD, 24'd100);
    write_reg(REG_RATIO_SLOPE, '0);
    close_writes();
    push_item(24'sd100, 1'b1);
    push_item(24'sd101, 1'b0);
    push_item(24'h80_0000, 1'b0);
    push_item(24'sd0, 1'b0);
    drain();

    // threshold beyond full scale never reduces; writes past the map dropped
    write_reg(REG_THRESHOLD, 24'hFF_FFFF);
    write_reg(REG_ATTACK, 24'(16'hFFFF));
    write_reg(REG_RELEASE, 24'(16'hFFFF));
    write_reg(REG_COUNT, '0);
    write_reg(REG_COUNT + envc_pkg::CFG_IDX_W'(3), 24'hFF_FFFF);
    close_writes();
    push_item(24'h7F_FFFF, 1'b1);
    push_item(24'h80_0000, 1'b0);
    push_item(24'sd0, 1'b0);
    push_item(24'hFF_FFFF, 1'b0);
    drain();

    // random part, a fresh register setting per phase
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      randomise_config();
      // one phase runs flat out on both sides
      src_idle_pct  = (ph == 2) ? 0 : 37;
      sink_idle_pct = (ph == 2) ? 0 : 37;
      // receiver sits out a long stretch so the block backs up on its input
      if (ph == 4) stall_requests++;
      queue_random(PHASE_ITEMS);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("envelope_compressor: match");
    else
      $display("envelope_compressor: mismatch");
    $finish;
  end

endmodule

[filelist.f]
rtl/envc_pkg.sv
rtl/envc_if.sv
rtl/envc_mul.sv
rtl/envc_core.sv
rtl/envelope_compressor.sv
dv/testbench.sv
